// ===== hdl/mp2a_pkg.sv =====
// Package for the 2-D max pooling block with argmax.
// Holds widths, register indexes, reset values and the sequencer states.
// No dependencies.
package mp2a_pkg;

    localparam int SAMPLE_W     = 16;
    localparam int INDEX_W      = 28;
    localparam int OUT_ROW_W    = 8;
    localparam int OUT_COL_W    = 8;
    localparam int OUT_PLANE_W  = 12;
    localparam int CFG_INDEX_W  = 3;
    localparam int CFG_DATA_W   = 13;
    localparam int KERNEL_W     = 4;
    localparam int STRIDE_W     = 4;
    localparam int PWIDTH_W     = 9;
    localparam int PHEIGHT_W    = 9;
    localparam int PCOUNT_W     = 13;

    localparam int DEF_MAX_WIDTH     = 256;
    localparam int DEF_MAX_HEIGHT    = 256;
    localparam int DEF_MAX_OPEN_ROWS = 8;
    localparam int DEF_MAX_PLANES    = 4096;

    localparam logic [CFG_INDEX_W-1:0] REG_KERNEL  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_STRIDE  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_PWIDTH  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_PHEIGHT = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_PCOUNT  = 3'd4;

    localparam logic [KERNEL_W-1:0]  RST_KERNEL  = 4'd2;
    localparam logic [STRIDE_W-1:0]  RST_STRIDE  = 4'd2;
    localparam logic [PWIDTH_W-1:0]  RST_PWIDTH  = 9'd256;
    localparam logic [PHEIGHT_W-1:0] RST_PHEIGHT = 9'd256;
    localparam logic [PCOUNT_W-1:0]  RST_PCOUNT  = 13'd1;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_ROW  = 4'b0010,
        S_COL  = 4'b0100,
        S_CMP  = 4'b1000
    } t_state;

endpackage

// ===== hdl/max_pool_2d_with_argmax.sv =====
// Streaming 2-D max pooling with argmax over raster-ordered planes.
// Depends on mp2a_pkg.
//
//  channel | direction | handshake                | payload
//  --------+-----------+--------------------------+-----------------------------------
//  in      | to block  | i_in_valid / o_in_stall  | i_sample
//  out     | from block| o_out_valid / i_out_stall| o_pooled_max .. o_plane_done
//  cfg     | to block  | i_cfg_we                 | i_cfg_index, i_cfg_data
//
// Each beat walks its candidate rows (S_ROW) and, for each row that fits, its candidate
// columns (S_COL), updating each fitting window in S_CMP; there are at most ceil(k/s) of
// each, and input is stalled until the walk returns to S_IDLE.
// The single read-compare-write path to the window memory sets the pace of that walk.
// Reset and any register write restart the stream at plane 0, row 0, column 0.
// A stalled output holds the sequencer at the window that completes.
module max_pool_2d_with_argmax #(
    parameter int MAX_WIDTH     = mp2a_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT    = mp2a_pkg::DEF_MAX_HEIGHT,
    parameter int MAX_OPEN_ROWS = mp2a_pkg::DEF_MAX_OPEN_ROWS,
    parameter int MAX_PLANES    = mp2a_pkg::DEF_MAX_PLANES
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_cfg_we,
    input  logic [mp2a_pkg::CFG_INDEX_W-1:0]        i_cfg_index,
    input  logic [mp2a_pkg::CFG_DATA_W-1:0]         i_cfg_data,
    input  logic                                    i_in_valid,
    output logic                                    o_in_stall,
    input  logic signed [mp2a_pkg::SAMPLE_W-1:0]    i_sample,
    output logic                                    o_out_valid,
    input  logic                                    i_out_stall,
    output logic signed [mp2a_pkg::SAMPLE_W-1:0]    o_pooled_max,
    output logic [mp2a_pkg::INDEX_W-1:0]            o_argmax_index,
    output logic [mp2a_pkg::OUT_ROW_W-1:0]          o_out_row,
    output logic [mp2a_pkg::OUT_COL_W-1:0]          o_out_col,
    output logic [mp2a_pkg::OUT_PLANE_W-1:0]        o_out_plane,
    output logic                                    o_plane_done
);
    import mp2a_pkg::*;

    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int RW    = $clog2(MAX_HEIGHT);
    localparam int PW    = (MAX_PLANES > 1) ? $clog2(MAX_PLANES) : 1;
    localparam int SW    = (MAX_OPEN_ROWS > 1) ? $clog2(MAX_OPEN_ROWS) : 1;
    localparam int DEPTH = MAX_OPEN_ROWS * MAX_WIDTH;
    localparam int AW    = $clog2(DEPTH);
    localparam int EW    = ((RW > CW) ? RW : CW) + 2;
    localparam int MW    = SAMPLE_W + INDEX_W;

    // configuration
    logic [KERNEL_W-1:0]  r_kernel;
    logic [STRIDE_W-1:0]  r_stride;
    logic [PWIDTH_W-1:0]  r_pwidth;
    logic [PHEIGHT_W-1:0] r_pheight;
    logic [PCOUNT_W-1:0]  r_pcount;

    logic [3:0]  k_eff, s_eff;
    logic [CW:0] w_eff;
    logic [RW:0] h_eff;
    logic [PW:0] p_eff;

    always_comb begin
        k_eff = (r_kernel == '0) ? 4'd1 : ((r_kernel > 4'd8) ? 4'd8 : r_kernel);
        s_eff = (r_stride == '0) ? 4'd1 : ((r_stride > 4'd8) ? 4'd8 : r_stride);
        // limit the window height to the rows that can be open at once
        if (32'(k_eff) > 32'(s_eff) * MAX_OPEN_ROWS)
            k_eff = 4'(32'(s_eff) * MAX_OPEN_ROWS);
        if (r_pwidth == '0)
            w_eff = (CW+1)'(1);
        else if (32'(r_pwidth) > MAX_WIDTH)
            w_eff = (CW+1)'(MAX_WIDTH);
        else
            w_eff = (CW+1)'(r_pwidth);
        if (r_pheight == '0)
            h_eff = (RW+1)'(1);
        else if (32'(r_pheight) > MAX_HEIGHT)
            h_eff = (RW+1)'(MAX_HEIGHT);
        else
            h_eff = (RW+1)'(r_pheight);
        if (r_pcount == '0)
            p_eff = (PW+1)'(1);
        else if (32'(r_pcount) > MAX_PLANES)
            p_eff = (PW+1)'(MAX_PLANES);
        else
            p_eff = (PW+1)'(r_pcount);
    end

    logic cfg_hit;
    assign cfg_hit = i_cfg_we && (i_cfg_index == REG_KERNEL || i_cfg_index == REG_STRIDE ||
                     i_cfg_index == REG_PWIDTH || i_cfg_index == REG_PHEIGHT ||
                     i_cfg_index == REG_PCOUNT);

    // stream position of the next sample
    logic [RW-1:0]      r_row, r_rdiv;
    logic [CW-1:0]      r_col, r_cdiv;
    logic [3:0]         r_rmod, r_cmod;
    logic [SW-1:0]      r_rslot;
    logic [PW-1:0]      r_plane;
    logic [INDEX_W-1:0] r_flat;

    // sample at work
    t_state                      r_state;
    logic signed [SAMPLE_W-1:0]  r_v;
    logic [RW-1:0]               r_r, r_oh;
    logic [CW-1:0]               r_c, r_ow, r_cdiv_cur;
    logic [3:0]                  r_kh, r_kw, r_cmod_cur;
    logic [SW-1:0]               r_ohs;
    logic [PW-1:0]               r_plane_cur;
    logic [INDEX_W-1:0]          r_idx;
    logic [AW-1:0]               r_addr;
    logic [MW-1:0]               r_rd;

    logic accept;
    assign accept     = i_in_valid && (r_state == S_IDLE);
    assign o_in_stall = (r_state != S_IDLE);

    // row and column candidate tests
    logic row_end, row_fit, col_end, col_fit;
    always_comb begin
        row_end = (r_kh >= k_eff) || (EW'(r_kh) > EW'(r_r));
        row_fit = (EW'(r_r) + EW'(k_eff)) <= (EW'(h_eff) + EW'(r_kh));
        col_end = (r_kw >= k_eff) || (EW'(r_kw) > EW'(r_c));
        col_fit = (EW'(r_c) + EW'(k_eff)) <= (EW'(w_eff) + EW'(r_kw));
    end

    logic [AW-1:0] rd_addr;
    assign rd_addr = AW'(r_ohs) * AW'(MAX_WIDTH) + AW'(r_ow);

    // compare against the stored partial result
    logic signed [SAMPLE_W-1:0] old_max;
    logic [INDEX_W-1:0]         old_arg;
    logic                       upd, emit, out_free, cmp_go;
    always_comb begin
        old_max  = r_rd[MW-1 -: SAMPLE_W];
        old_arg  = r_rd[INDEX_W-1:0];
        upd      = ((r_kh == '0) && (r_kw == '0)) || (r_v > old_max);
        emit     = (r_kh == k_eff - 4'd1) && (r_kw == k_eff - 4'd1);
        out_free = !o_out_valid || !i_out_stall;
        cmp_go   = (r_state == S_CMP) && (!emit || out_free);
    end

    logic out_load;
    assign out_load = cmp_go && emit;

    logic [SW-1:0] ohs_dec;
    assign ohs_dec = (r_ohs == '0) ? SW'(MAX_OPEN_ROWS - 1) : r_ohs - SW'(1);

    logic mem_rd;
    assign mem_rd = (r_state == S_COL) && !col_end && col_fit;

    logic [MW-1:0] mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (r_state == S_CMP && upd)
            mem[r_addr] <= {r_v, r_idx};
        if (mem_rd) begin
            r_rd   <= mem[rd_addr];
            r_addr <= rd_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kernel  <= RST_KERNEL;
            r_stride  <= RST_STRIDE;
            r_pwidth  <= RST_PWIDTH;
            r_pheight <= RST_PHEIGHT;
            r_pcount  <= RST_PCOUNT;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_KERNEL:  r_kernel  <= i_cfg_data[KERNEL_W-1:0];
                REG_STRIDE:  r_stride  <= i_cfg_data[STRIDE_W-1:0];
                REG_PWIDTH:  r_pwidth  <= i_cfg_data[PWIDTH_W-1:0];
                REG_PHEIGHT: r_pheight <= i_cfg_data[PHEIGHT_W-1:0];
                REG_PCOUNT:  r_pcount  <= i_cfg_data[PCOUNT_W-1:0];
                default: ;
            endcase
        end
    end

    // stream counters: advance on each accepted beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || cfg_hit) begin
            r_row   <= '0;
            r_col   <= '0;
            r_rdiv  <= '0;
            r_cdiv  <= '0;
            r_rmod  <= '0;
            r_cmod  <= '0;
            r_rslot <= '0;
            r_plane <= '0;
            r_flat  <= '0;
        end else if (accept) begin
            r_flat <= r_flat + INDEX_W'(1);
            if ((CW+1)'(r_col) + (CW+1)'(1) >= w_eff) begin
                r_col  <= '0;
                r_cdiv <= '0;
                r_cmod <= '0;
                if ((RW+1)'(r_row) + (RW+1)'(1) >= h_eff) begin
                    r_row   <= '0;
                    r_rdiv  <= '0;
                    r_rmod  <= '0;
                    r_rslot <= '0;
                    if ((PW+1)'(r_plane) + (PW+1)'(1) >= p_eff) begin
                        r_plane <= '0;
                        r_flat  <= '0;
                    end else begin
                        r_plane <= r_plane + PW'(1);
                    end
                end else begin
                    r_row <= r_row + RW'(1);
                    if (r_rmod + 4'd1 >= s_eff) begin
                        r_rmod  <= '0;
                        r_rdiv  <= r_rdiv + RW'(1);
                        r_rslot <= (32'(r_rslot) == MAX_OPEN_ROWS - 1) ? '0
                                                                       : r_rslot + SW'(1);
                    end else begin
                        r_rmod <= r_rmod + 4'd1;
                    end
                end
            end else begin
                r_col <= r_col + CW'(1);
                if (r_cmod + 4'd1 >= s_eff) begin
                    r_cmod <= '0;
                    r_cdiv <= r_cdiv + CW'(1);
                end else begin
                    r_cmod <= r_cmod + 4'd1;
                end
            end
        end
    end

    // sequencer over the windows that the sample falls in
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            o_out_valid <= 1'b0;
        end else begin
            if (out_load)
                o_out_valid <= 1'b1;
            else if (!i_out_stall)
                o_out_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_v         <= i_sample;
                        r_r         <= r_row;
                        r_c         <= r_col;
                        r_kh        <= r_rmod;
                        r_oh        <= r_rdiv;
                        r_ohs       <= r_rslot;
                        r_cmod_cur  <= r_cmod;
                        r_cdiv_cur  <= r_cdiv;
                        r_plane_cur <= r_plane;
                        r_idx       <= r_flat;
                        r_state     <= S_ROW;
                    end
                end
                S_ROW: begin
                    if (row_end) begin
                        r_state <= S_IDLE;
                    end else if (!row_fit) begin
                        r_kh  <= r_kh + s_eff;
                        r_oh  <= r_oh - RW'(1);
                        r_ohs <= ohs_dec;
                    end else begin
                        r_kw    <= r_cmod_cur;
                        r_ow    <= r_cdiv_cur;
                        r_state <= S_COL;
                    end
                end
                S_COL: begin
                    if (col_end) begin
                        r_kh    <= r_kh + s_eff;
                        r_oh    <= r_oh - RW'(1);
                        r_ohs   <= ohs_dec;
                        r_state <= S_ROW;
                    end else if (!col_fit) begin
                        r_kw <= r_kw + s_eff;
                        r_ow <= r_ow - CW'(1);
                    end else begin
                        r_state <= S_CMP;
                    end
                end
                S_CMP: begin
                    // hold a completing window here while the output register is full and stalled
                    if (cmp_go) begin
                        if (emit) begin
                            o_pooled_max   <= upd ? r_v : old_max;
                            o_argmax_index <= upd ? r_idx : old_arg;
                            o_out_row      <= OUT_ROW_W'(32'(r_oh));
                            o_out_col      <= OUT_COL_W'(32'(r_ow));
                            o_out_plane    <= OUT_PLANE_W'(32'(r_plane_cur));
                            o_plane_done   <=
                                ((EW'(r_r) + EW'(s_eff)) >= EW'(h_eff)) &&
                                ((EW'(r_c) + EW'(s_eff)) >= EW'(w_eff));
                        end
                        r_kw    <= r_kw + s_eff;
                        r_ow    <= r_ow - CW'(1);
                        r_state <= S_COL;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_pos_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> ((CW+1)'(r_col) < w_eff && (RW+1)'(r_row) < h_eff))
        else $error("stream position outside the plane");

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && !cfg_hit) |=> (r_state == S_ROW))
        else $error("accepted beat did not start the window walk");

    a_emit_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmp_go && emit) |=> o_out_valid)
        else $error("completed window not presented");

    a_mod_below_stride: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && !$past(cfg_hit)) |-> (r_cmod < s_eff && r_rmod < s_eff))
        else $error("phase counter reached the stride");

endmodule
